### hw/rtl/wrb_pkg.sv
// ----------------------------------------------------------------------------
// Water reflection blend package
// Widths, pipeline depth, register map and pixel format codes shared by the
// top level and the per-channel blend lanes.
// ----------------------------------------------------------------------------
package wrb_pkg;

  // One colour channel.
  localparam int CH_W = 8;

  // Every quotient of the blend fits in one channel, so one step per bit.
  localparam int DIV_STEPS = CH_W;

  // Input register, product stage, divider steps and output register.
  localparam int NUM_STAGES = DIV_STEPS + 3;

  // Alpha values driven on the result.
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  // Configuration port geometry.
  localparam int PADDR_W    = 4;
  localparam int APB_DATA_W = 32;
  localparam int FILL_W     = 3 * CH_W;

  // Register word index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_FILL_COLOR   = 2'd0,
    REG_WATER_HEIGHT = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } reg_idx_e;

  // Pixel format selector.
  typedef enum logic {
    FMT_24BPP = 1'b0,
    FMT_32BPP = 1'b1
  } pix_fmt_e;

endpackage

### hw/rtl/water_reflection_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// Water reflection pixel blend unit
// Blends a mirrored source pixel with a water tint, weighted by the row
// below the water line, in 24-bit or 32-bit (alpha scaled) pixel format.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake          | Content
//  s_axis    | in        | tvalid / tready    | source pixel and row index
//  m_axis    | out       | tvalid / tready    | blended pixel
//  apb       | in        | psel / penable     | fill colour, height, format
//
// Each item passes through 11 register stages: input, numerator products,
// eight restoring divider steps (one quotient bit each) and the output
// register, and one item is taken in every cycle while the output is not
// stalled. Reset clears the valid bits and the registers to tint 0, height 1
// and 24-bit format. A stalled output only holds as many stages as are full:
// bubbles close up and tready falls once the input stage is occupied and
// cannot move on.
// ----------------------------------------------------------------------------
module water_reflection_pixel_blend_unit
  import wrb_pkg::*;
#(
  parameter int MAX_WATER_ROWS = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input item
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] src_blue, [15:8] src_green, [23:16] src_red, [31:24] src_alpha,
  // then row_index, zero padded to whole bytes
  input  logic [((4*CH_W+$clog2(MAX_WATER_ROWS)+7)/8)*8-1:0] s_axis_tdata_i,
  // Result item
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] out_blue, [15:8] out_green, [23:16] out_red, [31:24] out_alpha
  output logic [4*CH_W-1:0]               m_axis_tdata_o,
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [PADDR_W-1:0]              paddr,
  input  logic [APB_DATA_W-1:0]           pwdata,
  output logic [APB_DATA_W-1:0]           prdata,
  output logic                            pready
);

  localparam int ROW_W = $clog2(MAX_WATER_ROWS);
  localparam logic [ROW_W-1:0] H_MAX = ROW_W'(MAX_WATER_ROWS - 1);
  localparam int ROW_LSB = 4 * CH_W;

  // Configuration registers.
  logic [FILL_W-1:0] fill_color_q;
  logic [ROW_W-1:0]  water_height_q;
  pix_fmt_e          pixel_format_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  // Pipeline control.
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] adv;

  // Derived blend constants.
  logic [ROW_W-1:0]      h_eff;
  logic [CH_W+ROW_W-1:0] div_src;
  logic                  wide;

  // Input stage.
  logic [ROW_W-1:0]  row_in;
  logic [ROW_W-1:0]  row_clamp;
  logic [ROW_W-1:0]  row_clamp_q;
  logic [ROW_W-1:0]  fill_weight_q;
  logic [2*CH_W-1:0] src_term   [0:2];
  logic [2*CH_W-1:0] src_term_q [0:2];

  // Register access.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q   <= '0;
      water_height_q <= ROW_W'(1);
      pixel_format_q <= FMT_24BPP;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FILL_COLOR:   fill_color_q   <= pwdata[FILL_W-1:0];
        REG_WATER_HEIGHT: water_height_q <= pwdata[ROW_W-1:0];
        REG_PIXEL_FORMAT: pixel_format_q <= pix_fmt_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FILL_COLOR:   prdata = APB_DATA_W'(fill_color_q);
      REG_WATER_HEIGHT: prdata = APB_DATA_W'(water_height_q);
      REG_PIXEL_FORMAT: prdata = APB_DATA_W'(pixel_format_q);
      default:          prdata = '0;
    endcase
  end

  // Effective height: zero reads as one, anything above the bound saturates.
  always_comb begin
    h_eff = water_height_q;
    if (water_height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (water_height_q > H_MAX) begin
      h_eff = H_MAX;
    end
  end

  // In 32-bit mode the alpha divide by 255 folds into the divisor.
  assign wide    = (pixel_format_q == FMT_32BPP);
  assign div_src = wide ? ({h_eff, {CH_W{1'b0}}} - (CH_W + ROW_W)'(h_eff))
                        : (CH_W + ROW_W)'(h_eff);

  // Stage enables: a stage moves when it is empty or the next one moves.
  always_comb begin
    adv[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = v_q[NUM_STAGES-1];

  // Row clamp, tint weight and alpha scaled source.
  assign row_in    = s_axis_tdata_i[ROW_LSB +: ROW_W];
  assign row_clamp = (row_in > h_eff) ? h_eff : row_in;

  for (genvar c = 0; c < 3; c++) begin : g_src
    assign src_term[c] = wide
      ? (2*CH_W)'(s_axis_tdata_i[c*CH_W +: CH_W]) * (2*CH_W)'(s_axis_tdata_i[3*CH_W +: CH_W])
      : (2*CH_W)'(s_axis_tdata_i[c*CH_W +: CH_W]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      row_clamp_q   <= row_clamp;
      fill_weight_q <= h_eff - row_clamp;
      for (int c = 0; c < 3; c++) begin
        src_term_q[c] <= src_term[c];
      end
    end
  end

  // One lane per colour channel; blue sits in the top byte of the tint.
  for (genvar c = 0; c < 3; c++) begin : g_lane
    wrb_lane #(
      .ROW_W (ROW_W)
    ) u_lane (
      .clk_i         (clk_i),
      .adv_i         (adv[NUM_STAGES-1:1]),
      .src_term_i    (src_term_q[c]),
      .row_clamp_i   (row_clamp_q),
      .fill_weight_i (fill_weight_q),
      .fill_i        (fill_color_q[(2-c)*CH_W +: CH_W]),
      .div_src_i     (div_src),
      .div_fill_i    (h_eff),
      .chan_o        (m_axis_tdata_o[c*CH_W +: CH_W])
    );
  end

  assign m_axis_tdata_o[3*CH_W +: CH_W] = wide ? ALPHA_OPAQUE : ALPHA_CLEAR;

  // An accepted item always lands in the input stage.
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v_q[0])
    else $error("accepted item did not enter the input stage");

  // Back-pressure only when the input stage holds an item.
  a_ready_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> v_q[0])
    else $error("input stalled with an empty input stage");

  // A full stage in front of an empty one always moves on.
  a_bubble_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !v_q[1]) |=> v_q[1])
    else $error("item held behind an empty stage");

endmodule

### hw/rtl/wrb_lane.sv
// ----------------------------------------------------------------------------
// Water reflection blend lane
// One colour channel: forms the source and tint numerators, divides both by
// restoring division one quotient bit per stage, then adds and saturates.
// ----------------------------------------------------------------------------
module wrb_lane
  import wrb_pkg::*;
#(
  parameter int ROW_W = 11
) (
  input  logic                  clk_i,
  // Load enables for the product stage, each divider step and the output.
  input  logic [DIV_STEPS+1:0]  adv_i,
  input  logic [2*CH_W-1:0]     src_term_i,
  input  logic [ROW_W-1:0]      row_clamp_i,
  input  logic [ROW_W-1:0]      fill_weight_i,
  input  logic [CH_W-1:0]       fill_i,
  input  logic [CH_W+ROW_W-1:0] div_src_i,
  input  logic [ROW_W-1:0]      div_fill_i,
  output logic [CH_W-1:0]       chan_o
);

  localparam int NUM_W = 2 * CH_W + ROW_W;

  // Partial remainders (index 0 holds the numerator) and quotients.
  logic [NUM_W-1:0] rem_s_q [0:DIV_STEPS-1];
  logic [NUM_W-1:0] rem_f_q [0:DIV_STEPS-1];
  logic [CH_W-1:0]  quo_s_q [0:DIV_STEPS-1];
  logic [CH_W-1:0]  quo_f_q [0:DIV_STEPS-1];
  logic [CH_W-1:0]  chan_q;
  logic [CH_W:0]    sum;

  // Numerators: weighted source and weighted tint.
  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      rem_s_q[0] <= NUM_W'(src_term_i) * NUM_W'(row_clamp_i);
      rem_f_q[0] <= NUM_W'(fill_i) * NUM_W'(fill_weight_i);
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int B = DIV_STEPS - 1 - k;
    logic [NUM_W-1:0] trial_s;
    logic [NUM_W-1:0] trial_f;
    logic             ge_s;
    logic             ge_f;
    logic [CH_W-1:0]  quo_s_prev;
    logic [CH_W-1:0]  quo_f_prev;

    assign trial_s = NUM_W'(div_src_i) << B;
    assign trial_f = NUM_W'(div_fill_i) << B;
    assign ge_s    = rem_s_q[k] >= trial_s;
    assign ge_f    = rem_f_q[k] >= trial_f;

    if (k == 0) begin : g_first
      assign quo_s_prev = '0;
      assign quo_f_prev = '0;
    end else begin : g_next
      assign quo_s_prev = quo_s_q[k-1];
      assign quo_f_prev = quo_f_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[k+1]) begin
        quo_s_q[k]    <= quo_s_prev | (CH_W'(ge_s) << B);
        quo_f_q[k]    <= quo_f_prev | (CH_W'(ge_f) << B);
      end
    end

    // The last step leaves no remainder that anyone needs.
    if (k < DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv_i[k+1]) begin
          rem_s_q[k+1] <= ge_s ? rem_s_q[k] - trial_s : rem_s_q[k];
          rem_f_q[k+1] <= ge_f ? rem_f_q[k] - trial_f : rem_f_q[k];
        end
      end
    end
  end

  // Sum of both parts, saturated to one channel.
  assign sum = {1'b0, quo_s_q[DIV_STEPS-1]} + {1'b0, quo_f_q[DIV_STEPS-1]};

  always_ff @(posedge clk_i) begin
    if (adv_i[DIV_STEPS+1]) begin
      chan_q <= sum[CH_W] ? ALPHA_OPAQUE : sum[CH_W-1:0];
    end
  end

  assign chan_o = chan_q;

endmodule
